// File: hw/rtl/bbvp_pkg.sv
// ----------------------------------------------------------------------------
// bbvp_pkg
// Shared types and constants for the basic block vector profiler.
// ----------------------------------------------------------------------------
package bbvp_pkg;

  localparam int PC_W       = 64;
  localparam int LEN_W      = 20;
  localparam int DUMPS_W    = 7;
  localparam int OVF_W      = 20;
  localparam int OUT_CNT_W  = 20;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF    = 20;

  localparam logic [LEN_W-1:0]   INTERVAL_LENGTH_RST = LEN_W'(50000);
  localparam logic [DUMPS_W-1:0] MAX_DUMPS_RST       = DUMPS_W'(101);
  localparam logic [PC_W-1:0]    PC_STEP             = PC_W'(4);

  // register index, taken from paddr[2]
  localparam logic REG_INTERVAL_LENGTH = 1'b0;
  localparam logic REG_MAX_DUMPS       = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_RECORD,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t      mode;
    logic            ins_en;  // no hit anywhere and table not full
    logic [PC_W-1:0] pc;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

endpackage

// File: hw/rtl/bbvp_if.sv
// ----------------------------------------------------------------------------
// bbvp_if
// Valid/ready channels for committed instructions and profile results.
// ----------------------------------------------------------------------------
interface bbvp_instr_if;
  logic        valid;
  logic        ready;
  logic [63:0] pc;
  logic        is_branch;

  modport source (output valid, pc, is_branch, input ready);
  modport sink   (input valid, pc, is_branch, output ready);
endinterface

interface bbvp_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_pc;
  logic [19:0] block_count;
  logic        entry_valid;
  logic [6:0]  interval_number;
  logic [19:0] overflow_count;
  logic        last_of_dump;

  modport source (output valid, block_pc, block_count, entry_valid, interval_number,
                  overflow_count, last_of_dump, input ready);
  modport sink   (input valid, block_pc, block_count, entry_valid, interval_number,
                  overflow_count, last_of_dump, output ready);
endinterface

// File: hw/rtl/basic_block_vector_profiler.sv
// Results: after a closing instruction is taken, the state register enters dump and the
//   result register loads the chain head; one result per cycle when the sink is ready.
// Intake: one instruction per cycle between intervals; a closing interval that is dumped
//   stops intake until the chain has shifted out, one result per valid entry (one if empty).
// Reset: synchronous; table empty, counters zero, registers to their defaults.
// ----------------------------------------------------------------------------
// basic_block_vector_profiler
// Counts basic block starts per interval in a sorted chain of cells and dumps
// the chain in ascending address order at the end of the first max_dumps intervals.
// ----------------------------------------------------------------------------
module basic_block_vector_profiler #(
  parameter int TABLE_ENTRIES = bbvp_pkg::TABLE_ENTRIES_DEF,
  parameter int COUNT_BITS    = bbvp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  bbvp_instr_if.sink                      instr,
  bbvp_block_if.source                    block,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbvp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bbvp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bbvp_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bbvp_pkg::*;

  // configuration
  logic [LEN_W-1:0]   interval_length;
  logic [DUMPS_W-1:0] max_dumps;
  logic               cfg_wr;
  logic               reg_idx;

  // sequencing state
  state_t             state, state_next;
  logic [PC_W-1:0]    previous_pc;
  logic               previous_was_branch;
  logic               previous_was_delay_slot;
  logic [LEN_W-1:0]   instr_count;
  logic [LEN_W-1:0]   instr_count_inc;
  logic [DUMPS_W-1:0] intervals_emitted;
  logic [OVF_W-1:0]   dropped;

  logic accept;
  logic same_block;
  logic closing;
  logic dump_allowed;
  logic load;
  logic last_load;
  logic full;
  logic hit_any;

  cell_ctrl_t ctrl;

  // chain storage; index TABLE_ENTRIES is the empty fill-in from the right
  logic                  used_a  [0:TABLE_ENTRIES];
  logic [63:0]           addr_a  [0:TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] count_a [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] gt_v;
  logic [TABLE_ENTRIES-1:0] hit_v;
  logic [31:0]           head_count;

  assign used_a[TABLE_ENTRIES]  = 1'b0;
  assign addr_a[TABLE_ENTRIES]  = '0;
  assign count_a[TABLE_ENTRIES] = '0;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_length <= INTERVAL_LENGTH_RST;
      max_dumps       <= MAX_DUMPS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INTERVAL_LENGTH: interval_length <= pwdata[LEN_W-1:0];
        REG_MAX_DUMPS:       max_dumps       <= pwdata[DUMPS_W-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INTERVAL_LENGTH: prdata = APB_DATA_W'(interval_length);
      REG_MAX_DUMPS:       prdata = APB_DATA_W'(max_dumps);
      default:             prdata = '0;
    endcase
  end

  // ---------------- instruction side ----------------
  assign accept          = instr.valid && instr.ready;
  assign same_block      = ((instr.pc == previous_pc + PC_STEP) && !previous_was_delay_slot)
                           || (instr.pc == '0);
  assign instr_count_inc = instr_count + LEN_W'(1);
  assign closing         = instr_count_inc >= interval_length;
  assign dump_allowed    = intervals_emitted < max_dumps;
  assign full            = used_a[TABLE_ENTRIES-1];
  assign hit_any         = |hit_v;

  assign load      = (state == ST_DUMP) && (!block.valid || block.ready);
  assign last_load = load && (!used_a[0] || !used_a[1]);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && closing && dump_allowed) state_next = ST_DUMP;
      ST_DUMP: if (last_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    instr.ready = 1'b0;
    ctrl.mode   = CELL_HOLD;
    ctrl.ins_en = !hit_any && !full;
    ctrl.pc     = instr.pc;
    case (state)
      ST_IDLE: begin
        instr.ready = 1'b1;
        if (accept) begin
          if (closing && !dump_allowed) begin
            ctrl.mode = CELL_CLEAR;
          end else if (!same_block) begin
            ctrl.mode = CELL_RECORD;
          end
        end
      end
      ST_DUMP: begin
        if (load) ctrl.mode = CELL_SHIFT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                   <= ST_IDLE;
      previous_pc             <= '0;
      previous_was_branch     <= 1'b0;
      previous_was_delay_slot <= 1'b0;
      instr_count             <= '0;
      intervals_emitted       <= '0;
      dropped                 <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        previous_pc             <= instr.pc;
        previous_was_delay_slot <= previous_was_branch;
        previous_was_branch     <= instr.is_branch;
        instr_count             <= closing ? '0 : instr_count_inc;
        if (closing && !dump_allowed) begin
          dropped <= '0;
        end else if (!same_block && !hit_any && full && (dropped != '1)) begin
          dropped <= dropped + OVF_W'(1);
        end
      end
      if (last_load) begin
        intervals_emitted <= intervals_emitted + DUMPS_W'(1);
        dropped           <= '0;
      end
    end
  end

  // ---------------- chain of cells ----------------
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic                  gt_left;
    logic                  l_used;
    logic [63:0]           l_addr;
    logic [COUNT_BITS-1:0] l_count;

    if (i == 0) begin : g_head
      assign gt_left = 1'b0;
      assign l_used  = 1'b0;
      assign l_addr  = '0;
      assign l_count = '0;
    end else begin : g_body
      assign gt_left = gt_v[i-1];
      assign l_used  = used_a[i-1];
      assign l_addr  = addr_a[i-1];
      assign l_count = count_a[i-1];
    end

    bbvp_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .gt_prev     (gt_left),
      .left_used   (l_used),
      .left_addr   (l_addr),
      .left_count  (l_count),
      .right_used  (used_a[i+1]),
      .right_addr  (addr_a[i+1]),
      .right_count (count_a[i+1]),
      .used        (used_a[i]),
      .addr        (addr_a[i]),
      .count       (count_a[i]),
      .gt          (gt_v[i]),
      .hit         (hit_v[i])
    );
  end

  // ---------------- result register ----------------
  assign head_count = 32'(count_a[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      block.valid <= 1'b0;
    end else if (load) begin
      block.valid <= 1'b1;
    end else if (block.ready) begin
      block.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      block.block_pc        <= used_a[0] ? addr_a[0] : '0;
      block.block_count     <= used_a[0] ? head_count[OUT_CNT_W-1:0] : '0;
      block.entry_valid     <= used_a[0];
      block.interval_number <= intervals_emitted;
      block.overflow_count  <= dropped;
      block.last_of_dump    <= !used_a[0] || !used_a[1];
    end
  end

endmodule

// File: hw/rtl/bbvp_cell.sv
// ----------------------------------------------------------------------------
// bbvp_cell
// One table entry of the sorted chain: count a hit or insert/shift right on record,
// shift left on dump, emptied on clear.
// ----------------------------------------------------------------------------
module bbvp_cell #(
  parameter int COUNT_BITS = bbvp_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bbvp_pkg::cell_ctrl_t  ctrl,
  input  logic                  gt_prev,
  input  logic                  left_used,
  input  logic [63:0]           left_addr,
  input  logic [COUNT_BITS-1:0] left_count,
  input  logic                  right_used,
  input  logic [63:0]           right_addr,
  input  logic [COUNT_BITS-1:0] right_count,
  output logic                  used,
  output logic [63:0]           addr,
  output logic [COUNT_BITS-1:0] count,
  output logic                  gt,
  output logic                  hit
);
  import bbvp_pkg::*;

  logic ins_here;
  logic take_left;

  // entries are kept sorted with used ones first, so gt is monotone
  assign gt        = !used || (addr > ctrl.pc);
  assign hit       = used && (addr == ctrl.pc);
  assign ins_here  = ctrl.ins_en && gt && !gt_prev;
  assign take_left = ctrl.ins_en && gt_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      case (ctrl.mode)
        CELL_RECORD: begin
          if (ins_here) begin
            used <= 1'b1;
          end else if (take_left) begin
            used <= left_used;
          end
        end
        CELL_SHIFT: used <= right_used;
        CELL_CLEAR: used <= 1'b0;
        default:    used <= used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CELL_RECORD: begin
        if (hit) begin
          if (count != '1) begin
            count <= count + COUNT_BITS'(1);
          end
        end else if (ins_here) begin
          addr  <= ctrl.pc;
          count <= COUNT_BITS'(1);
        end else if (take_left) begin
          addr  <= left_addr;
          count <= left_count;
        end
      end
      CELL_SHIFT: begin
        addr  <= right_addr;
        count <= right_count;
      end
      default: begin
        addr  <= addr;
        count <= count;
      end
    endcase
  end

endmodule

// File: hw/rtl/bbvp_checker.sv
// ----------------------------------------------------------------------------
// bbvp_checker
// Port-level checks on the profiler's result stream.
// ----------------------------------------------------------------------------
module bbvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_block_pc,
  input logic [19:0] out_block_count,
  input logic        out_entry_valid,
  input logic [6:0]  out_interval_number,
  input logic        out_last
);

  // a stalled result holds its pc, count and last flag
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_block_pc)
      && $stable(out_block_count) && $stable(out_last))
    else $error("result changed while stalled");

  // an empty interval is a single marker result
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_entry_valid |-> out_last && out_block_count == '0
      && out_block_pc == '0)
    else $error("empty interval marker malformed");

  // a real entry was entered at least once
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_entry_valid |-> out_block_count != '0)
    else $error("valid entry with zero count");

  // within a run, entries ascend and share the interval number
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last ##1 out_valid |->
      out_block_pc > $past(out_block_pc)
      && out_interval_number == $past(out_interval_number))
    else $error("dump run out of order");

endmodule

bind basic_block_vector_profiler bbvp_checker u_bbvp_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (block.valid),
  .out_ready           (block.ready),
  .out_block_pc        (block.block_pc),
  .out_block_count     (block.block_count),
  .out_entry_valid     (block.entry_valid),
  .out_interval_number (block.interval_number),
  .out_last            (block.last_of_dump)
);
